// File: design/sfd_pkg.sv
package sfd_pkg;

   localparam int STORE_DEPTH_DEF = 131072;
   localparam int SAMPLE_BITS_DEF = 24;
   localparam int GAIN_BITS_DEF = 16;

   localparam int DELAY_BITS = 17;
   localparam int FEEDBACK_BITS = 15;
   localparam int MIX_BITS = 16;

   localparam int CSR_ADDR_BITS = 4;
   localparam int CSR_DATA_BITS = 32;

   localparam logic [DELAY_BITS-1:0] DELAY_RESET = 17'd15435;
   localparam logic [FEEDBACK_BITS-1:0] FEEDBACK_RESET = 15'd11469;
   localparam logic [MIX_BITS-1:0] MIX_RESET = 16'd13107;

   typedef enum logic [1:0] {
      REG_DELAY    = 2'd0,
      REG_FEEDBACK = 2'd1,
      REG_MIX      = 2'd2
   } reg_index_type;

   // Per-lane controls for the read/compute stage.
   typedef struct packed {
      logic load;      // a new frame enters the compute stage
      logic move;      // the frame in the compute stage writes back and moves on
      logic use_fwd;   // delayed sample comes from the previous frame's write
      logic use_zero;  // delayed sample address was never written since reset
   } lane_ctl_type;

endpackage

// File: design/sfd_lane.sv
module sfd_lane #(
   parameter int STORE_DEPTH = sfd_pkg::STORE_DEPTH_DEF,
   parameter int SAMPLE_BITS = sfd_pkg::SAMPLE_BITS_DEF,
   parameter int GAIN_BITS = sfd_pkg::GAIN_BITS_DEF,
   localparam int AW = $clog2(STORE_DEPTH),
   localparam int PW = SAMPLE_BITS + GAIN_BITS + 1
) (
   input  logic                          clock,
   input  sfd_pkg::lane_ctl_type         ctl,
   input  logic [AW-1:0]                 rd_addr,
   input  logic [AW-1:0]                 wr_addr,
   input  logic signed [SAMPLE_BITS-1:0] sample_in,
   input  logic [GAIN_BITS-1:0]          fb_gain,
   input  logic [GAIN_BITS-1:0]          wet_gain,
   input  logic [GAIN_BITS-1:0]          dry_gain,
   output logic signed [PW-1:0]          dry_prod,
   output logic signed [PW-1:0]          wet_prod
);

   localparam logic signed [PW:0] HALF = (PW+1)'(2 ** (GAIN_BITS - 2));
   localparam logic signed [PW:0] SMAX = {{(PW-SAMPLE_BITS+2){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic signed [PW:0] SMIN = {{(PW-SAMPLE_BITS+2){1'b1}}, {(SAMPLE_BITS-1){1'b0}}};

   logic [SAMPLE_BITS-1:0] store_mem [STORE_DEPTH];

   logic signed [SAMPLE_BITS-1:0] x_ff;
   logic signed [SAMPLE_BITS-1:0] rdata_ff;
   logic signed [SAMPLE_BITS-1:0] fwd_ff;
   logic signed [PW-1:0]          dry_prod_ff;
   logic signed [PW-1:0]          wet_prod_ff;

   logic signed [SAMPLE_BITS-1:0] delayed;
   logic signed [PW-1:0]          x_w;
   logic signed [PW-1:0]          d_w;
   logic signed [PW-1:0]          fbg_w;
   logic signed [PW-1:0]          wet_w;
   logic signed [PW-1:0]          dry_w;
   logic signed [PW-1:0]          fb_prod;
   logic signed [PW:0]            fb_ext;
   logic signed [PW:0]            x_ext;
   logic signed [PW:0]            fb_round;
   logic signed [PW:0]            fb_sum;
   logic signed [SAMPLE_BITS-1:0] fed;

   always_comb begin
      if (ctl.use_fwd) begin
         delayed = fwd_ff;
      end else if (ctl.use_zero) begin
         delayed = '0;
      end else begin
         delayed = rdata_ff;
      end
   end

   assign x_w   = PW'(x_ff);
   assign d_w   = PW'(delayed);
   assign fbg_w = $signed({{(PW-GAIN_BITS){1'b0}}, fb_gain});
   assign wet_w = $signed({{(PW-GAIN_BITS){1'b0}}, wet_gain});
   assign dry_w = $signed({{(PW-GAIN_BITS){1'b0}}, dry_gain});

   // Feedback term rounds half up, then the sum saturates before write-back.
   assign fb_prod  = d_w * fbg_w;
   assign fb_ext   = (PW+1)'(fb_prod);
   assign x_ext    = (PW+1)'(x_ff);
   assign fb_round = (fb_ext + HALF) >>> (GAIN_BITS - 1);
   assign fb_sum   = fb_round + x_ext;

   always_comb begin
      if (fb_sum > SMAX) begin
         fed = SMAX[SAMPLE_BITS-1:0];
      end else if (fb_sum < SMIN) begin
         fed = SMIN[SAMPLE_BITS-1:0];
      end else begin
         fed = fb_sum[SAMPLE_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         x_ff     <= sample_in;
         rdata_ff <= store_mem[rd_addr];
      end
      if (ctl.move) begin
         store_mem[wr_addr] <= fed;
         fwd_ff             <= fed;
         dry_prod_ff        <= x_w * dry_w;
         wet_prod_ff        <= d_w * wet_w;
      end
   end

   assign dry_prod = dry_prod_ff;
   assign wet_prod = wet_prod_ff;

endmodule

// File: design/sfd_merge.sv
module sfd_merge #(
   parameter int SAMPLE_BITS = sfd_pkg::SAMPLE_BITS_DEF,
   parameter int GAIN_BITS = sfd_pkg::GAIN_BITS_DEF,
   localparam int PW = SAMPLE_BITS + GAIN_BITS + 1
) (
   input  logic signed [PW-1:0]          left_dry,
   input  logic signed [PW-1:0]          left_wet,
   input  logic signed [PW-1:0]          right_dry,
   input  logic signed [PW-1:0]          right_wet,
   output logic signed [SAMPLE_BITS-1:0] left_out,
   output logic signed [SAMPLE_BITS-1:0] right_out
);

   localparam logic signed [PW:0] HALF = (PW+1)'(2 ** (GAIN_BITS - 2));
   localparam logic signed [PW:0] SMAX = {{(PW-SAMPLE_BITS+2){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic signed [PW:0] SMIN = {{(PW-SAMPLE_BITS+2){1'b1}}, {(SAMPLE_BITS-1){1'b0}}};

   // Dry and wet shares add up, round half up to the sample scale and saturate.
   function automatic logic [SAMPLE_BITS-1:0] mix_round(input logic signed [PW-1:0] dry,
                                                        input logic signed [PW-1:0] wet);
      logic signed [PW:0] dry_ext;
      logic signed [PW:0] wet_ext;
      logic signed [PW:0] total;
      logic [SAMPLE_BITS-1:0] res;
      dry_ext = (PW+1)'(dry);
      wet_ext = (PW+1)'(wet);
      total = (dry_ext + wet_ext + HALF) >>> (GAIN_BITS - 1);
      if (total > SMAX) begin
         res = SMAX[SAMPLE_BITS-1:0];
      end else if (total < SMIN) begin
         res = SMIN[SAMPLE_BITS-1:0];
      end else begin
         res = total[SAMPLE_BITS-1:0];
      end
      return res;
   endfunction

   assign left_out  = mix_round(left_dry, left_wet);
   assign right_out = mix_round(right_dry, right_wet);

endmodule

// File: design/stereo_feedback_delay_top.sv
// Each accepted frame is registered, then its products are registered and merged.
// Throughput: one frame per cycle without stalls, for any delay; the store read port is
// registered and the write-back of the previous frame is forwarded when addresses match.
// Reset clears the pipeline, the write pointer and the registers to their defaults.
// The stores are not swept: an entry not written since reset reads as zero.
module stereo_feedback_delay_top #(
   parameter int STORE_DEPTH = sfd_pkg::STORE_DEPTH_DEF,
   parameter int SAMPLE_BITS = sfd_pkg::SAMPLE_BITS_DEF,
   parameter int GAIN_BITS = sfd_pkg::GAIN_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [SAMPLE_BITS-1:0]        req_left_in,
   input  logic signed [SAMPLE_BITS-1:0]        req_right_in,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [SAMPLE_BITS-1:0]        rsp_left_out,
   output logic signed [SAMPLE_BITS-1:0]        rsp_right_out,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [sfd_pkg::CSR_ADDR_BITS-1:0]    csr_paddr,
   input  logic [sfd_pkg::CSR_DATA_BITS-1:0]    csr_pwdata,
   output logic [sfd_pkg::CSR_DATA_BITS-1:0]    csr_prdata,
   output logic                                 csr_pready
);

   localparam int AW = $clog2(STORE_DEPTH);
   localparam int PW = SAMPLE_BITS + GAIN_BITS + 1;
   localparam int GAIN_ONE = 2 ** (GAIN_BITS - 1);
   localparam int FB_MAX = (GAIN_ONE * 95) / 100;
   localparam logic [AW-1:0] LAST_ADDR = AW'(STORE_DEPTH - 1);

   // Configuration registers.
   logic [sfd_pkg::DELAY_BITS-1:0]    delay_ff;
   logic [sfd_pkg::FEEDBACK_BITS-1:0] feedback_ff;
   logic [sfd_pkg::MIX_BITS-1:0]      mix_ff;
   logic                              csr_write;
   sfd_pkg::reg_index_type            csr_index;

   // Pipeline control.
   logic          b_valid_ff;
   logic          b_valid_in;
   logic          c_valid_ff;
   logic          c_valid_in;
   logic [AW-1:0] iss_ptr_ff;
   logic [AW-1:0] iss_ptr_in;
   logic          iss_wrapped_ff;
   logic          iss_wrapped_in;
   logic [AW-1:0] b_wp_ff;
   logic          b_fwd_ff;
   logic          b_zero_ff;
   logic          c_free;
   logic          b_go;
   logic          accept;
   logic          b_move;

   logic [AW-1:0]          delay_eff;
   logic [AW:0]            rd_wide;
   logic [AW-1:0]          rd_addr;
   logic                   rd_fwd;
   logic                   rd_zero;
   logic [GAIN_BITS-1:0]   fb_eff;
   logic [GAIN_BITS-1:0]   wet_eff;
   logic [GAIN_BITS-1:0]   dry_eff;
   sfd_pkg::lane_ctl_type  lane_ctl;

   logic signed [PW-1:0] left_dry;
   logic signed [PW-1:0] left_wet;
   logic signed [PW-1:0] right_dry;
   logic signed [PW-1:0] right_wet;

   // ---------------- configuration port ----------------
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = sfd_pkg::reg_index_type'(csr_paddr[3:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         delay_ff    <= sfd_pkg::DELAY_RESET;
         feedback_ff <= sfd_pkg::FEEDBACK_RESET;
         mix_ff      <= sfd_pkg::MIX_RESET;
      end else if (csr_write) begin
         case (csr_index)
            sfd_pkg::REG_DELAY: begin
               delay_ff <= csr_pwdata[sfd_pkg::DELAY_BITS-1:0];
            end
            sfd_pkg::REG_FEEDBACK: begin
               feedback_ff <= csr_pwdata[sfd_pkg::FEEDBACK_BITS-1:0];
            end
            sfd_pkg::REG_MIX: begin
               mix_ff <= csr_pwdata[sfd_pkg::MIX_BITS-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         sfd_pkg::REG_DELAY: begin
            csr_prdata = sfd_pkg::CSR_DATA_BITS'(delay_ff);
         end
         sfd_pkg::REG_FEEDBACK: begin
            csr_prdata = sfd_pkg::CSR_DATA_BITS'(feedback_ff);
         end
         sfd_pkg::REG_MIX: begin
            csr_prdata = sfd_pkg::CSR_DATA_BITS'(mix_ff);
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

   // ---------------- limited settings ----------------
   assign delay_eff = (32'(delay_ff) > 32'(STORE_DEPTH - 1)) ? LAST_ADDR : AW'(delay_ff);
   assign fb_eff    = (32'(feedback_ff) > 32'(FB_MAX)) ? GAIN_BITS'(FB_MAX)
                                                       : GAIN_BITS'(feedback_ff);
   assign wet_eff   = (32'(mix_ff) > 32'(GAIN_ONE)) ? GAIN_BITS'(GAIN_ONE)
                                                    : GAIN_BITS'(mix_ff);
   assign dry_eff   = GAIN_BITS'(GAIN_ONE) - wet_eff;

   // ---------------- handshake and pipeline ----------------
   // No beat is taken while reset is held.
   assign c_free    = !c_valid_ff || !rsp_stall;
   assign b_go      = !b_valid_ff || c_free;
   assign req_stall = reset || !b_go;
   assign accept    = req_valid && b_go && !reset;
   assign b_move    = b_valid_ff && c_free;
   assign rsp_valid = c_valid_ff;

   // Read address wraps below zero back into the top of the store.
   always_comb begin
      if (iss_ptr_ff >= delay_eff) begin
         rd_wide = (AW+1)'(iss_ptr_ff) - (AW+1)'(delay_eff);
      end else begin
         rd_wide = (AW+1)'(iss_ptr_ff) + (AW+1)'(STORE_DEPTH) - (AW+1)'(delay_eff);
      end
   end
   assign rd_addr = rd_wide[AW-1:0];

   // The frame in the compute stage writes back at the same edge as this read.
   assign rd_fwd  = b_move && (b_wp_ff == rd_addr);
   // Addresses are written in order from zero, so until the pointer first wraps
   // only the entries below it have ever been written.
   assign rd_zero = !(iss_wrapped_ff || (rd_addr < iss_ptr_ff));

   always_comb begin
      b_valid_in     = b_valid_ff;
      c_valid_in     = c_valid_ff;
      iss_ptr_in     = iss_ptr_ff;
      iss_wrapped_in = iss_wrapped_ff;
      if (accept) begin
         b_valid_in = 1'b1;
         if (iss_ptr_ff == LAST_ADDR) begin
            iss_ptr_in     = '0;
            iss_wrapped_in = 1'b1;
         end else begin
            iss_ptr_in = iss_ptr_ff + 1'b1;
         end
      end else if (b_move) begin
         b_valid_in = 1'b0;
      end
      if (b_move) begin
         c_valid_in = 1'b1;
      end else if (c_valid_ff && !rsp_stall) begin
         c_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff     <= 1'b0;
         c_valid_ff     <= 1'b0;
         iss_ptr_ff     <= '0;
         iss_wrapped_ff <= 1'b0;
         b_fwd_ff       <= 1'b0;
         b_zero_ff      <= 1'b1;
      end else begin
         b_valid_ff     <= b_valid_in;
         c_valid_ff     <= c_valid_in;
         iss_ptr_ff     <= iss_ptr_in;
         iss_wrapped_ff <= iss_wrapped_in;
         if (accept) begin
            b_fwd_ff  <= rd_fwd;
            b_zero_ff <= rd_zero;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         b_wp_ff <= iss_ptr_ff;
      end
   end

   assign lane_ctl.load     = accept;
   assign lane_ctl.move     = b_move;
   assign lane_ctl.use_fwd  = b_fwd_ff;
   assign lane_ctl.use_zero = b_zero_ff;

   // ---------------- lanes and merge ----------------
   sfd_lane #(
      .STORE_DEPTH (STORE_DEPTH),
      .SAMPLE_BITS (SAMPLE_BITS),
      .GAIN_BITS   (GAIN_BITS)
   ) u_left (
      .clock     (clock),
      .ctl       (lane_ctl),
      .rd_addr   (rd_addr),
      .wr_addr   (b_wp_ff),
      .sample_in (req_left_in),
      .fb_gain   (fb_eff),
      .wet_gain  (wet_eff),
      .dry_gain  (dry_eff),
      .dry_prod  (left_dry),
      .wet_prod  (left_wet)
   );

   sfd_lane #(
      .STORE_DEPTH (STORE_DEPTH),
      .SAMPLE_BITS (SAMPLE_BITS),
      .GAIN_BITS   (GAIN_BITS)
   ) u_right (
      .clock     (clock),
      .ctl       (lane_ctl),
      .rd_addr   (rd_addr),
      .wr_addr   (b_wp_ff),
      .sample_in (req_right_in),
      .fb_gain   (fb_eff),
      .wet_gain  (wet_eff),
      .dry_gain  (dry_eff),
      .dry_prod  (right_dry),
      .wet_prod  (right_wet)
   );

   sfd_merge #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .GAIN_BITS   (GAIN_BITS)
   ) u_merge (
      .left_dry  (left_dry),
      .left_wet  (left_wet),
      .right_dry (right_dry),
      .right_wet (right_wet),
      .left_out  (rsp_left_out),
      .right_out (rsp_right_out)
   );

   // ---------------- assertions ----------------
   a_ptr_step: assert property (@(posedge clock) disable iff (reset)
      accept |=> iss_ptr_ff == (($past(iss_ptr_ff) == LAST_ADDR) ? '0
                                                                : $past(iss_ptr_ff) + 1'b1))
      else $error("write pointer did not advance by one frame");

   a_wrap_sticky: assert property (@(posedge clock) disable iff (reset)
      iss_wrapped_ff |=> iss_wrapped_ff)
      else $error("wrap flag cleared without reset");

   a_fwd_written: assert property (@(posedge clock) disable iff (reset)
      (b_valid_ff && b_fwd_ff) |-> !b_zero_ff)
      else $error("forwarded entry marked as never written");

   a_move_fills: assert property (@(posedge clock) disable iff (reset)
      b_move |=> c_valid_ff)
      else $error("frame leaving compute stage was lost");

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 100ps

module testbench;

   localparam int ECHO_DEPTH = 131072;
   localparam longint GAIN_ONE = 32768;
   localparam longint FEEDBACK_MAX = (GAIN_ONE * 95) / 100;
   localparam longint SAT_HI = 8388607;
   localparam longint SAT_LO = -8388608;
   localparam logic signed [23:0] PEAK_POS = 24'sh7FFFFF;
   localparam logic signed [23:0] PEAK_NEG = 24'sh800000;
   localparam logic [3:0] ADDR_DELAY = {sfd_pkg::REG_DELAY, 2'b00};
   localparam logic [3:0] ADDR_FEEDBACK = {sfd_pkg::REG_FEEDBACK, 2'b00};
   localparam logic [3:0] ADDR_MIX = {sfd_pkg::REG_MIX, 2'b00};
   // First word past the register list; writes there must have no effect.
   localparam logic [3:0] ADDR_UNUSED = 4'd12;
   localparam int DRAIN_CYCLES = 4;
   localparam int RANDOM_FRAMES = 1500;
   localparam int CYCLE_LIMIT = 1000000;

   typedef struct packed {
      logic signed [23:0] left;
      logic signed [23:0] right;
   } frame_type;

   logic clock = 1'b0;
   logic reset;
   logic req_valid;
   logic req_stall;
   logic signed [23:0] req_left_in;
   logic signed [23:0] req_right_in;
   logic rsp_valid;
   logic rsp_stall;
   logic signed [23:0] rsp_left_out;
   logic signed [23:0] rsp_right_out;
   logic csr_psel;
   logic csr_penable;
   logic csr_pwrite;
   logic [sfd_pkg::CSR_ADDR_BITS-1:0] csr_paddr;
   logic [sfd_pkg::CSR_DATA_BITS-1:0] csr_pwdata;
   logic [sfd_pkg::CSR_DATA_BITS-1:0] csr_prdata;
   logic csr_pready;

   // Shadow state of the echo: both delay lines, the shared write pointer and registers.
   logic signed [23:0] left_echo [0:ECHO_DEPTH-1];
   logic signed [23:0] right_echo [0:ECHO_DEPTH-1];
   logic [16:0] echo_wr_ptr;
   logic [sfd_pkg::DELAY_BITS-1:0] delay_shadow;
   logic [sfd_pkg::FEEDBACK_BITS-1:0] feedback_shadow;
   logic [sfd_pkg::MIX_BITS-1:0] mix_shadow;

   frame_type expected_frames[$];
   int frames_sent;
   int error_count;
   int cycle_count = 0;
   bit quiet;

   stereo_feedback_delay_top dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_left_in(req_left_in),
      .req_right_in(req_right_in),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_left_out(rsp_left_out),
      .rsp_right_out(rsp_right_out),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always #5 clock = ~clock;

   function automatic longint round_gain(longint v);
      return (v + GAIN_ONE / 2) >>> 15;
   endfunction

   function automatic logic signed [23:0] clamp_sample(longint v);
      if (v > SAT_HI) begin
         return PEAK_POS;
      end
      if (v < SAT_LO) begin
         return PEAK_NEG;
      end
      return v[23:0];
   endfunction

   function automatic void echo_channel(input longint x, input longint d, input longint fb,
                                        input longint mix, output logic signed [23:0] fed,
                                        output logic signed [23:0] mixed);
      fed = clamp_sample(x + round_gain(d * fb));
      mixed = clamp_sample(round_gain(x * (GAIN_ONE - mix) + d * mix));
   endfunction

   function automatic frame_type echo_predict(logic signed [23:0] left,
                                              logic signed [23:0] right);
      logic [16:0] rd_ptr;
      longint fb;
      longint mix;
      logic signed [23:0] left_fed;
      logic signed [23:0] right_fed;
      frame_type result;
      fb = (feedback_shadow > FEEDBACK_MAX) ? FEEDBACK_MAX : longint'(feedback_shadow);
      mix = (mix_shadow > GAIN_ONE) ? GAIN_ONE : longint'(mix_shadow);
      // The delay register cannot exceed the depth minus one, so the subtraction wraps
      // naturally; a zero delay reads the slot that is about to be overwritten.
      rd_ptr = echo_wr_ptr - delay_shadow;
      echo_channel(left, left_echo[rd_ptr], fb, mix, left_fed, result.left);
      echo_channel(right, right_echo[rd_ptr], fb, mix, right_fed, result.right);
      left_echo[echo_wr_ptr] = left_fed;
      right_echo[echo_wr_ptr] = right_fed;
      echo_wr_ptr = echo_wr_ptr + 17'd1;
      return result;
   endfunction

   function automatic void apply_register(logic [3:0] addr, logic [31:0] data);
      case (sfd_pkg::reg_index_type'(addr[3:2]))
         sfd_pkg::REG_DELAY: delay_shadow = data[sfd_pkg::DELAY_BITS-1:0];
         sfd_pkg::REG_FEEDBACK: feedback_shadow = data[sfd_pkg::FEEDBACK_BITS-1:0];
         sfd_pkg::REG_MIX: mix_shadow = data[sfd_pkg::MIX_BITS-1:0];
         default: ;
      endcase
   endfunction

   function automatic logic [31:0] register_value(logic [3:0] addr);
      case (sfd_pkg::reg_index_type'(addr[3:2]))
         sfd_pkg::REG_DELAY: return 32'(delay_shadow);
         sfd_pkg::REG_FEEDBACK: return 32'(feedback_shadow);
         sfd_pkg::REG_MIX: return 32'(mix_shadow);
         default: return '0;
      endcase
   endfunction

   function automatic logic signed [23:0] pick_sample();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 60) begin
         return 24'($urandom);
      end
      if (roll < 80) begin
         case ($urandom_range(3))
            0: return PEAK_POS;
            1: return PEAK_NEG;
            2: return 24'sd0;
            default: return -24'sd1;
         endcase
      end
      return 24'($urandom_range(2047)) - 24'sd1024;
   endfunction

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("stereo_feedback_delay_top regression: fail");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_stall <= !quiet && ($urandom_range(99) < 15);
   end

   // Every output beat is matched against the oldest predicted frame.
   always @(posedge clock) begin
      frame_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_frames.size() == 0) begin
            $error("output beat with no frame expected: left %0d, right %0d",
                   rsp_left_out, rsp_right_out);
            error_count++;
         end else begin
            want = expected_frames.pop_front();
            if (rsp_left_out !== want.left) begin
               $error("left_out mismatch: expected %0d, actual %0d", want.left, rsp_left_out);
               error_count++;
            end
            if (rsp_right_out !== want.right) begin
               $error("right_out mismatch: expected %0d, actual %0d",
                      want.right, rsp_right_out);
               error_count++;
            end
         end
      end
   end

   task automatic send_frame(logic signed [23:0] left, logic signed [23:0] right);
      req_valid <= 1'b1;
      req_left_in <= left;
      req_right_in <= right;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_frames.push_back(echo_predict(left, right));
      frames_sent++;
      if (!quiet && $urandom_range(99) < 15) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   task automatic wait_pipeline_empty();
      req_valid <= 1'b0;
      while (expected_frames.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(logic [3:0] addr, logic [31:0] data);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= addr;
      csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      apply_register(addr, data);
      @(posedge clock);
   endtask

   task automatic csr_check(logic [3:0] addr, string name);
      logic [31:0] got;
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= addr;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      got = csr_prdata;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      if (got !== register_value(addr)) begin
         $error("%s mismatch: expected %0d, actual %0d", name, register_value(addr), got);
         error_count++;
      end
      @(posedge clock);
   endtask

   task automatic set_echo(logic [31:0] delay, logic [31:0] feedback, logic [31:0] mix);
      wait_pipeline_empty();
      csr_write(ADDR_DELAY, delay);
      csr_write(ADDR_FEEDBACK, feedback);
      csr_write(ADDR_MIX, mix);
   endtask

   task automatic test_directed_frames();
      // Reset settings with a long delay: the output is the dry share only.
      send_frame(PEAK_POS, PEAK_NEG);
      send_frame(PEAK_NEG, PEAK_POS);
      send_frame(24'sd0, -24'sd1);
      send_frame(-24'sd1, 24'sd0);
      // One-frame delay with the largest feedback: the delay line saturates; dry output.
      set_echo(1, 32'(FEEDBACK_MAX), 0);
      repeat (4) send_frame(PEAK_POS, PEAK_POS);
      repeat (3) send_frame(PEAK_NEG, PEAK_NEG);
      // Feedback and mix above their limits are clamped.
      set_echo(2, 32767, 65535);
      send_frame(PEAK_POS, PEAK_NEG);
      send_frame(PEAK_NEG, PEAK_POS);
      send_frame(24'sd12345, -24'sd12345);
      send_frame(PEAK_POS, PEAK_POS);
      send_frame(24'sd1, -24'sd1);
      // Zero delay reads the slot being replaced, fully wet.
      set_echo(0, 0, 32768);
      repeat (3) send_frame(PEAK_POS, PEAK_NEG);
      // Longest delay.
      set_echo(131071, 16384, 16384);
      send_frame(PEAK_NEG, PEAK_POS);
      send_frame(24'sd4096, -24'sd4096);
      send_frame(PEAK_POS, PEAK_NEG);
   endtask

   task automatic test_register_access();
      wait_pipeline_empty();
      csr_check(ADDR_DELAY, "delay_samples");
      csr_check(ADDR_FEEDBACK, "feedback_gain");
      csr_check(ADDR_MIX, "wet_mix");
      // Bits above each register's width are dropped.
      csr_write(ADDR_DELAY, 32'hFFFF_FFFF);
      csr_write(ADDR_FEEDBACK, 32'hFFFF_FFFF);
      csr_write(ADDR_MIX, 32'hFFFF_FFFF);
      csr_write(ADDR_UNUSED, 32'h0000_0000);
      csr_check(ADDR_DELAY, "delay_samples");
      csr_check(ADDR_FEEDBACK, "feedback_gain");
      csr_check(ADDR_MIX, "wet_mix");
      send_frame(PEAK_POS, PEAK_NEG);
      send_frame(24'sd777, -24'sd777);
   endtask

   task automatic random_echo_setting();
      logic [31:0] delay;
      logic [31:0] feedback;
      logic [31:0] mix;
      case ($urandom_range(9))
         0: delay = 0;
         1: delay = 131071;
         2: delay = $urandom;
         default: delay = $urandom_range(1, 64);
      endcase
      case ($urandom_range(9))
         0: feedback = 0;
         1: feedback = 32'(FEEDBACK_MAX);
         2: feedback = 32767;
         3: feedback = $urandom;
         default: feedback = $urandom_range(0, 32767);
      endcase
      case ($urandom_range(9))
         0: mix = 0;
         1: mix = 32768;
         2: mix = 65535;
         3: mix = $urandom;
         default: mix = $urandom_range(0, 32768);
      endcase
      set_echo(delay, feedback, mix);
      if ($urandom_range(3) == 0) begin
         csr_check(ADDR_DELAY, "delay_samples");
         csr_check(ADDR_FEEDBACK, "feedback_gain");
         csr_check(ADDR_MIX, "wet_mix");
      end
   endtask

   task automatic test_random_traffic();
      int target;
      int phase;
      target = frames_sent + RANDOM_FRAMES;
      phase = 0;
      while (frames_sent < target) begin
         random_echo_setting();
         quiet = (phase == 3);
         repeat ($urandom_range(20, 150)) send_frame(pick_sample(), pick_sample());
         phase++;
      end
      quiet = 1'b0;
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_left_in = '0;
      req_right_in = '0;
      rsp_stall = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      quiet = 1'b0;
      frames_sent = 0;
      error_count = 0;
      for (int i = 0; i < ECHO_DEPTH; i++) begin
         left_echo[i] = '0;
         right_echo[i] = '0;
      end
      echo_wr_ptr = '0;
      delay_shadow = sfd_pkg::DELAY_RESET;
      feedback_shadow = sfd_pkg::FEEDBACK_RESET;
      mix_shadow = sfd_pkg::MIX_RESET;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_directed_frames();
      test_register_access();
      test_random_traffic();

      wait_pipeline_empty();
      repeat (8) @(posedge clock);
      if (error_count == 0) begin
         $display("stereo_feedback_delay_top regression: pass");
      end else begin
         $display("stereo_feedback_delay_top regression: fail");
      end
      $finish;
   end

endmodule
